[src/gregorian_day_difference_macros.svh]
// Assertion macros shared by the day-count RTL.
// Included by the modules that assert; expects i_clk and i_rst_n in scope.
`ifndef GREGORIAN_DAY_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DAY_DIFFERENCE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define GDD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdd assertion failed");

// Implication with a delay given by the argument n.
`define GDD_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error("gdd assertion failed");

`endif

[src/gdd_pkg.sv]
// Package for the Gregorian day-count block: field widths, constants and
// the cumulative month table. No dependencies.
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DIFF_W  = 23;
    localparam int DNUM_W  = 23;   // day number of a date, unsigned
    localparam int DOY_W   = 10;   // day of year, at most 397

    // x / 25 == (x * RECIP25) >> RECIP_SH for x below 43690
    localparam logic [12:0] RECIP25  = 13'd5243;
    localparam int          RECIP_SH = 17;

    localparam int LATENCY = 4;

    localparam logic signed [DIFF_W-1:0] DIFF_MAX = 23'sh3FFFFF;
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = 23'sh400000;

    // Days in the full months before month m of a common year.
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

endpackage

[src/gregorian_day_difference.sv]
// Top level of the Gregorian day-count block: two day-number lanes and a
// subtract / saturate stage. Uses gdd_pkg, gdd_day_number and the macros.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  item in  | in        | start, busy (always low)| i_first_*, i_second_*
//  result   | out       | o_done strobe, 1 cycle  | o_day_difference (signed)
//  config   | in        | i_cfg_wr_en             | i_cfg_wr_data (count_end_day)
//
// One item per cycle; each result leaves the subtract/saturate stage after the
// three stages of the day-number lanes, once its item is taken.
// Synchronous active-low reset clears the valid chain and the config bit;
// data registers are not reset. busy is tied low: nothing stalls, and the
// receiver must take every strobed result.
`timescale 1ns / 1ps

`include "gregorian_day_difference_macros.svh"

module gregorian_day_difference (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [gdd_pkg::DAY_W-1:0]             i_first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]           i_first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]            i_first_year,
    input  logic [gdd_pkg::DAY_W-1:0]             i_second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]           i_second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]            i_second_year,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  i_cfg_wr_data,
    output logic                                  o_done,
    output logic signed [gdd_pkg::DIFF_W-1:0]     o_day_difference
);

    // config: count both end dates
    logic r_count_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_end <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_count_end <= i_cfg_wr_data;
        end
    end

    assign busy = 1'b0;

    // valid chain alongside the three lane stages
    logic [2:0] r_vld;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 3'b000;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], start && !busy};
            r_done <= r_vld[2];
        end
    end

    logic [gdd_pkg::DNUM_W-1:0] dn_first;
    logic [gdd_pkg::DNUM_W-1:0] dn_second;

    gdd_day_number u_first (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_day        (i_first_day),
        .i_month      (i_first_month),
        .i_year       (i_first_year),
        .o_day_number (dn_first)
    );

    gdd_day_number u_second (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_day        (i_second_day),
        .i_month      (i_second_month),
        .i_year       (i_second_year),
        .o_day_number (dn_second)
    );

    // stage 4: signed difference, end-day count, clamp to the result width
    logic signed [24:0] n_raw;
    logic signed [gdd_pkg::DIFF_W-1:0] n_diff;
    logic signed [gdd_pkg::DIFF_W-1:0] r_diff;

    assign n_raw = $signed({2'b00, dn_second}) - $signed({2'b00, dn_first})
                 + $signed({24'd0, r_count_end});

    always_comb begin
        if (n_raw > 25'(gdd_pkg::DIFF_MAX)) begin
            n_diff = gdd_pkg::DIFF_MAX;
        end else if (n_raw < 25'(gdd_pkg::DIFF_MIN)) begin
            n_diff = gdd_pkg::DIFF_MIN;
        end else begin
            n_diff = n_raw[gdd_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
    end

    assign o_done           = r_done;
    assign o_day_difference = r_diff;

    `GDD_ASSERT_DELAY(a_item_done, start && !busy, 4, o_done)
    `GDD_ASSERT_DELAY(a_no_spurious, !start, 4, !o_done)

endmodule

[src/gdd_day_number.sv]
// Three-stage day number of one date: days of all years before it plus
// day of year. Uses gdd_pkg and gregorian_day_difference_macros.svh.
`timescale 1ns / 1ps

`include "gregorian_day_difference_macros.svh"

module gdd_day_number (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gdd_pkg::DAY_W-1:0]       i_day,
    input  logic [gdd_pkg::MONTH_W-1:0]     i_month,
    input  logic [gdd_pkg::YEAR_W-1:0]      i_year,
    output logic [gdd_pkg::DNUM_W-1:0]      o_day_number
);

    // stage 1: quotient products
    logic [12:0] n_a;   // (y + 99) / 4
    logic [10:0] n_b;   // (y + 399) / 16
    logic [25:0] r1_pa;
    logic [23:0] r1_pb;
    logic [24:0] r1_pc;
    logic [22:0] r1_pe;
    logic [12:0] r1_q4;
    logic [gdd_pkg::DNUM_W-1:0]  r1_y365;
    logic [gdd_pkg::YEAR_W-1:0]  r1_y;
    logic [gdd_pkg::MONTH_W-1:0] r1_m;
    logic [gdd_pkg::DAY_W-1:0]   r1_d;

    assign n_a = 13'((15'(i_year) + 15'd99) >> 2);
    assign n_b = 11'((15'(i_year) + 15'd399) >> 4);

    always_ff @(posedge i_clk) begin
        r1_pa   <= 26'(n_a) * 26'(gdd_pkg::RECIP25);
        r1_pb   <= 24'(n_b) * 24'(gdd_pkg::RECIP25);
        r1_pc   <= 25'(i_year[13:2]) * 25'(gdd_pkg::RECIP25);
        r1_pe   <= 23'(i_year[13:4]) * 23'(gdd_pkg::RECIP25);
        r1_q4   <= 13'((15'(i_year) + 15'd3) >> 2);
        r1_y365 <= 23'(i_year) * 23'd365;
        r1_y    <= i_year;
        r1_m    <= i_month;
        r1_d    <= i_day;
    end

    // stage 2: leap flag, days before year, day of year
    logic [8:0]  q100;
    logic [6:0]  q400;
    logic [7:0]  qc;     // (y / 4) / 25
    logic [5:0]  qe;     // (y / 16) / 25
    logic        n_cent;
    logic        n_quad;
    logic        n_leap;
    logic [gdd_pkg::DNUM_W-1:0] n_dby;
    logic [gdd_pkg::DOY_W-1:0]  n_doy;
    logic [gdd_pkg::DNUM_W-1:0] r2_dby;
    logic [gdd_pkg::DOY_W-1:0]  r2_doy;
    logic                       r2_leap;

    assign q100 = r1_pa[25:gdd_pkg::RECIP_SH];
    assign q400 = r1_pb[23:gdd_pkg::RECIP_SH];
    assign qc   = r1_pc[24:gdd_pkg::RECIP_SH];
    assign qe   = r1_pe[22:gdd_pkg::RECIP_SH];

    // divisible by 100 / by 400, given divisible by 4 / by 16
    assign n_cent = (13'(qc) * 13'd25) == 13'(r1_y[13:2]);
    assign n_quad = (r1_y[3:2] == 2'b00) && ((11'(qe) * 11'd25) == 11'(r1_y[13:4]));
    assign n_leap = (r1_y[1:0] == 2'b00) && (!n_cent || n_quad);

    assign n_dby = r1_y365 + 23'(r1_q4) - 23'(q100) + 23'(q400);
    assign n_doy = 10'(gdd_pkg::cum_days(r1_m))
                 + 10'(n_leap && (r1_m > 4'd2))
                 + 10'(r1_d);

    always_ff @(posedge i_clk) begin
        r2_dby  <= n_dby;
        r2_doy  <= n_doy;
        r2_leap <= n_leap;
    end

    // stage 3: day number
    logic [gdd_pkg::DNUM_W-1:0] r3_dn;

    always_ff @(posedge i_clk) begin
        r3_dn <= r2_dby + 23'(r2_doy);
    end

    assign o_day_number = r3_dn;

    `GDD_ASSERT_IMPLIES(a_leap_div4, r2_leap, $past(r1_y[1:0]) == 2'b00)
    `GDD_ASSERT_IMPLIES(a_doy_range, 1'b1, r2_doy <= 10'd397)

endmodule
